[rtl/vefm_pkg.sv]
package vefm_pkg;

  localparam int CHUNK_SIZE_DEF = 16;
  localparam int FACE_COUNT = 6;
  localparam int ID_W = 16;

  localparam logic [1:0] OP_WRITE_BLOCK = 2'd0;
  localparam logic [1:0] OP_WRITE_FACE  = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [3:0]      pos_x;
    logic [3:0]      pos_y;
    logic [3:0]      pos_z;
    logic [ID_W-1:0] id_value;
    logic [2:0]      face;
  } vefm_item_t;

  typedef struct packed {
    logic [ID_W-1:0]       block_id;
    logic [FACE_COUNT-1:0] exposed_faces;
  } vefm_result_t;

  typedef struct packed {
    logic en;
    logic we;
  } vefm_chunk_ctl_t;

  typedef struct packed {
    logic       en;
    logic [1:0] wmask;
  } vefm_plane_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NEIGH,
    ST_LAST,
    ST_DONE
  } vefm_state_t;

endpackage

[rtl/vefm_chunk_mem.sv]
module vefm_chunk_mem import vefm_pkg::*; #(
  parameter int AW = 12
) (
  input  logic            clk,
  input  vefm_chunk_ctl_t ctl,
  input  logic [AW-1:0]   addr,
  input  logic [ID_W-1:0] wdata,
  output logic [ID_W-1:0] rdata
);

  logic [ID_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/vefm_plane_mem.sv]
module vefm_plane_mem import vefm_pkg::*; #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  vefm_plane_ctl_t ctl,
  input  logic [AW-1:0]   addr,
  input  logic [1:0]      wdata,
  output logic [1:0]      rdata
);

  logic [1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (|ctl.wmask) begin
        if (ctl.wmask[0]) begin
          mem[addr][0] <= wdata[0];
        end
        if (ctl.wmask[1]) begin
          mem[addr][1] <= wdata[1];
        end
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/vefm_ctrl.sv]
module vefm_ctrl import vefm_pkg::*; #(
  parameter int CHUNK_SIZE = CHUNK_SIZE_DEF,
  localparam int CW = $clog2(CHUNK_SIZE),
  localparam int CA_W = 3 * CW,
  localparam int PA_W = 2 * CW + 2,
  localparam int CLR_W = (CA_W > PA_W) ? CA_W : PA_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  vefm_item_t            item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output vefm_result_t          result,
  input  logic                  cfg_we,
  input  logic [FACE_COUNT-1:0] cfg_data,
  output vefm_chunk_ctl_t       chunk_ctl,
  output logic [CA_W-1:0]       chunk_addr,
  output logic [ID_W-1:0]       chunk_wdata,
  input  logic [ID_W-1:0]       chunk_rdata,
  output vefm_plane_ctl_t       plane_ctl,
  output logic [PA_W-1:0]       plane_addr,
  output logic [1:0]            plane_wdata,
  input  logic [1:0]            plane_rdata
);

  vefm_state_t           state, state_next;
  logic [2:0]            step, step_next;
  logic [CLR_W-1:0]      clr_cnt, clr_cnt_next;
  logic [FACE_COUNT-1:0] present;
  logic [CW-1:0]         cx, cy, cz;
  logic                  hit;
  logic [ID_W-1:0]       bid;
  logic [FACE_COUNT-1:0] mask;
  logic                  pend_edge;
  logic [2:0]            pend_face;

  logic          accept, load, exposed;
  logic          rx, ry, rz, in_range, face_ok;
  logic [CW-1:0] icx, icy, icz;
  logic [1:0]    iaxis, naxis;
  logic [CW-1:0] ia, ib, na, nb;
  logic [CW-1:0] nc, ncoord, nx, ny, nz;
  logic          npos, nedge;

  assign accept = item_valid && item_ready;
  assign load = (state == ST_DONE) && (!result_valid || result_ready);

  assign icx = CW'(item.pos_x);
  assign icy = CW'(item.pos_y);
  assign icz = CW'(item.pos_z);
  assign rx = int'(item.pos_x) < CHUNK_SIZE;
  assign ry = int'(item.pos_y) < CHUNK_SIZE;
  assign rz = int'(item.pos_z) < CHUNK_SIZE;
  assign in_range = rx && ry && rz;

  assign iaxis = item.face[2:1];
  assign ia = (iaxis == 2'd0) ? icy : icx;
  assign ib = (iaxis == 2'd2) ? icy : icz;
  assign face_ok = (item.face < 3'(FACE_COUNT)) &&
                   ((iaxis == 2'd0) ? ry : rx) && ((iaxis == 2'd2) ? ry : rz);

  assign naxis = step[2:1];
  assign npos = !step[0];
  assign nc = (naxis == 2'd0) ? cx : ((naxis == 2'd1) ? cy : cz);
  assign nedge = npos ? (nc == CW'(CHUNK_SIZE - 1)) : (nc == '0);
  assign ncoord = npos ? nc + CW'(1) : nc - CW'(1);
  assign nx = (naxis == 2'd0) ? ncoord : cx;
  assign ny = (naxis == 2'd1) ? ncoord : cy;
  assign nz = (naxis == 2'd2) ? ncoord : cz;
  assign na = (naxis == 2'd0) ? cy : cx;
  assign nb = (naxis == 2'd2) ? cy : cz;

  assign exposed = pend_edge ? (!present[pend_face] || !plane_rdata[pend_face[0]])
                             : (chunk_rdata == '0);

  always_comb begin
    state_next   = state;
    step_next    = step;
    clr_cnt_next = clr_cnt;
    item_ready   = (state == ST_IDLE);
    chunk_ctl    = '0;
    chunk_addr   = {nz, ny, nx};
    chunk_wdata  = item.id_value;
    plane_ctl    = '0;
    plane_addr   = {naxis, nb, na};
    plane_wdata  = {2{|item.id_value}};
    unique case (state)
      ST_CLEAR: begin
        chunk_ctl    = '{en: 1'b1, we: 1'b1};
        chunk_addr   = clr_cnt[CA_W-1:0];
        chunk_wdata  = '0;
        plane_ctl    = '{en: 1'b1, wmask: 2'b11};
        plane_addr   = clr_cnt[PA_W-1:0];
        plane_wdata  = '0;
        clr_cnt_next = clr_cnt + CLR_W'(1);
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item.opcode)
            OP_WRITE_BLOCK: begin
              chunk_ctl  = '{en: in_range, we: 1'b1};
              chunk_addr = {icz, icy, icx};
            end
            OP_WRITE_FACE: begin
              plane_ctl.en    = face_ok;
              plane_ctl.wmask = item.face[0] ? 2'b10 : 2'b01;
              plane_addr      = {iaxis, ib, ia};
            end
            OP_QUERY: begin
              chunk_ctl  = '{en: in_range, we: 1'b0};
              chunk_addr = {icz, icy, icx};
              step_next  = '0;
              state_next = in_range ? ST_NEIGH : ST_DONE;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_NEIGH: begin
        chunk_ctl = '{en: 1'b1, we: 1'b0};
        plane_ctl = '{en: 1'b1, wmask: 2'b00};
        step_next = step + 3'd1;
        if (step == 3'(FACE_COUNT - 1)) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      step         <= '0;
      clr_cnt      <= '0;
      present      <= '0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      clr_cnt <= clr_cnt_next;
      if (cfg_we) begin
        present <= cfg_data;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx   <= icx;
      cy   <= icy;
      cz   <= icz;
      hit  <= in_range;
      mask <= '0;
    end
    if (state == ST_NEIGH) begin
      pend_edge <= nedge;
      pend_face <= step;
      if (step == '0) begin
        bid <= chunk_rdata;
      end
    end
    if ((state == ST_NEIGH && step != '0) || state == ST_LAST) begin
      mask[pend_face] <= exposed;
    end
    if (load) begin
      result.block_id      <= hit ? bid : '0;
      result.exposed_faces <= (hit && bid != '0) ? mask : '0;
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");

  a_empty_no_faces: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.block_id == '0) |-> result.exposed_faces == '0)
    else $error("empty block reports exposed faces");

  a_last_after_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LAST) |-> ($past(state) == ST_NEIGH && $past(step) == 3'(FACE_COUNT - 1)))
    else $error("neighbor sweep cut short");

  a_miss_skips_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && item.opcode == OP_QUERY && !in_range) |=> state == ST_DONE)
    else $error("out of range query entered neighbor sweep");

endmodule

[rtl/voxel_exposed_face_mask.sv]
// Voxel chunk face culling. Holds a cubic chunk of 16-bit block ids and six
// one-bit boundary planes of the neighbor chunks. Block writes and boundary
// writes are done in the cycle they are taken. A query holds off the input until
// its result is loaded into the result register, which waits while that register
// is full: the chunk store has a single port, so the center cell and its six
// neighbors are read one per cycle, then the mask is settled and registered; an
// out-of-range query skips the reads. After reset the block sweeps both stores to
// empty and takes no item until the sweep ends; neighbor-present writes (cfg_we)
// are taken at any time outside reset.
module voxel_exposed_face_mask import vefm_pkg::*; #(
  parameter int CHUNK_SIZE = CHUNK_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  vefm_item_t            item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output vefm_result_t          result,
  input  logic                  cfg_we,
  input  logic [FACE_COUNT-1:0] cfg_data
);

  localparam int CW = $clog2(CHUNK_SIZE);
  localparam int CA_W = 3 * CW;
  localparam int PA_W = 2 * CW + 2;

  vefm_chunk_ctl_t chunk_ctl;
  logic [CA_W-1:0] chunk_addr;
  logic [ID_W-1:0] chunk_wdata, chunk_rdata;
  vefm_plane_ctl_t plane_ctl;
  logic [PA_W-1:0] plane_addr;
  logic [1:0]      plane_wdata, plane_rdata;

  vefm_ctrl #(
    .CHUNK_SIZE(CHUNK_SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .chunk_ctl    (chunk_ctl),
    .chunk_addr   (chunk_addr),
    .chunk_wdata  (chunk_wdata),
    .chunk_rdata  (chunk_rdata),
    .plane_ctl    (plane_ctl),
    .plane_addr   (plane_addr),
    .plane_wdata  (plane_wdata),
    .plane_rdata  (plane_rdata)
  );

  vefm_chunk_mem #(
    .AW(CA_W)
  ) u_chunk_mem (
    .clk   (clk),
    .ctl   (chunk_ctl),
    .addr  (chunk_addr),
    .wdata (chunk_wdata),
    .rdata (chunk_rdata)
  );

  vefm_plane_mem #(
    .AW(PA_W)
  ) u_plane_mem (
    .clk   (clk),
    .ctl   (plane_ctl),
    .addr  (plane_addr),
    .wdata (plane_wdata),
    .rdata (plane_rdata)
  );

endmodule
